// ----- hw/rtl/rihp_pkg.sv -----
// types and constants shared by the cartridge header parser modules
// no dependencies
package rihp_pkg;

	localparam int HDR_KEEP = 14;
	localparam int REC_COUNT_BITS = 32;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	localparam logic [7:0] SIG_0 = 8'h4E;
	localparam logic [7:0] SIG_1 = 8'h45;
	localparam logic [7:0] SIG_2 = 8'h53;
	localparam logic [7:0] SIG_3 = 8'h1A;

	localparam logic [31:0] HDR_BYTES = 32'd16;
	localparam logic [31:0] TRAINER_BYTES = 32'd512;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_SIG   = 3'd2,
		ST_VS        = 3'd3,
		ST_ARCADE    = 3'd4,
		ST_ZERO_PRG  = 3'd5,
		ST_TRUNCATED = 3'd6
	} status_t;

	localparam logic [1:0] CONSOLE_VS     = 2'd1;
	localparam logic [1:0] CONSOLE_ARCADE = 2'd2;
	localparam logic [1:0] CONSOLE_EXT    = 2'd3;

	localparam logic [1:0] MIRROR_HORIZ = 2'd0;
	localparam logic [1:0] MIRROR_VERT  = 2'd1;
	localparam logic [1:0] MIRROR_FOUR  = 2'd2;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  header_flags;
		logic [11:0] mapper_num;
		logic [3:0]  submapper;
		logic [25:0] prg_rom_bytes;
		logic [24:0] chr_rom_bytes;
		logic [21:0] prg_wram_bytes;
		logic [21:0] prg_nvram_bytes;
		logic [21:0] chr_ram_bytes;
		logic [21:0] chr_nvram_bytes;
		logic [1:0]  timing_mode;
		logic [63:0] fingerprint;
	} out_item_t;

	// one finished image handed from the front to the decoder
	typedef struct packed {
		logic [HDR_KEEP-1:0][7:0]  hdr;
		logic [REC_COUNT_BITS-1:0] count;
		logic [63:0]               hash;
	} hdr_rec_t;

endpackage

// ----- hw/rtl/rom_image_header_parser.sv -----
// cartridge image header parser: one byte per cycle in while the record queue has room, one result per image out
// a result reaches the ports by a record queue write, then combinational decode
// into the result queue; the decode waits while the result queue is full
// throughput: 1 byte per cycle while the record queue has room; hash update is one shift-add step per byte
// images as short as one byte can follow each other every cycle while the record queue has room
// reset (async, active low) empties both queues and restarts count and hash
module rom_image_header_parser import rihp_pkg::*; #(
	parameter int COUNT_BITS = 27
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	hdr_rec_t rec_in, rec_out;
	out_item_t res;
	logic rec_push, rec_pop, rec_empty, res_push, res_full;

	rihp_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(push && !full),
		.item(item),
		.rec_push(rec_push),
		.rec(rec_in)
	);

	rihp_fifo #(
		.item_t(hdr_rec_t),
		.DEPTH(2)
	) u_rec_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(rec_push),
		.wdata(rec_in),
		.full(full),
		.pop(rec_pop),
		.rdata(rec_out),
		.empty(rec_empty)
	);

	rihp_back u_back (
		.rec(rec_out),
		.rec_empty(rec_empty),
		.rec_pop(rec_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res)
	);

	rihp_fifo #(
		.item_t(out_item_t),
		.DEPTH(2)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res),
		.full(res_full),
		.pop(pop),
		.rdata(result),
		.empty(empty)
	);

endmodule

// ----- hw/rtl/rihp_fifo.sv -----
// small register queue used between the parser stages and at the result port
// depends on nothing but its type parameter
module rihp_fifo #(
	parameter type item_t = logic,
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

	item_t mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- hw/rtl/rihp_front.sv -----
// byte intake: header capture, saturating byte count, running FNV-1a hash
// depends on rihp_pkg
module rihp_front import rihp_pkg::*; #(
	parameter int COUNT_BITS = 27
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     rec_push,
	output hdr_rec_t rec
);

	logic [COUNT_BITS-1:0] count_q, count_nxt;
	logic [63:0] hash_q, hash_x, hash_nxt;
	logic [7:0] hdr_q [HDR_KEEP];

	// multiply by the FNV prime 2^40 + 0x1b3 as shifts and adds
	assign hash_x = hash_q ^ {56'd0, item.file_byte};
	assign hash_nxt = (hash_x << 40) + (hash_x << 8) + (hash_x << 7) + (hash_x << 5)
		+ (hash_x << 4) + (hash_x << 1) + hash_x;

	assign count_nxt = (count_q == '1) ? count_q : count_q + 1'b1;

	// a header that passes the length test never has its last byte in the store
	always_comb begin
		for (int i = 0; i < HDR_KEEP; i++) begin
			rec.hdr[i] = hdr_q[i];
		end
		rec.count = REC_COUNT_BITS'(count_nxt);
		rec.hash = hash_nxt;
	end

	assign rec_push = accept && item.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hash_q <= FNV_BASIS;
		end else if (accept) begin
			if (item.last_byte) begin
				count_q <= '0;
				hash_q <= FNV_BASIS;
			end else begin
				count_q <= count_nxt;
				hash_q <= hash_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && count_q < COUNT_BITS'(HDR_KEEP)) begin
			hdr_q[count_q[3:0]] <= item.file_byte;
		end
	end

endmodule

// ----- hw/rtl/rihp_back.sv -----
// header decode and status checks for one finished image
// depends on rihp_pkg
module rihp_back import rihp_pkg::*; (
	input  hdr_rec_t  rec,
	input  logic      rec_empty,
	output logic      rec_pop,
	input  logic      res_full,
	output logic      res_push,
	output out_item_t res
);

	logic [HDR_KEEP-1:0][7:0] h;
	logic v2, trainer, battery, sig_ok, short_img;
	logic [1:0] console, mirror;
	logic [11:0] mapper, prg_units, chr_units;
	logic [3:0] sub;
	logic [25:0] prg;
	logic [24:0] chr;
	logic [21:0] pram, pnv, cram, cnv;
	logic [1:0] tv;
	logic [31:0] need;
	status_t status;

	function automatic logic [21:0] ram_shift(input logic [3:0] nib);
		return (nib == 4'd0) ? 22'd0 : (22'd64 << nib);
	endfunction

	assign res_push = !rec_empty && !res_full;
	assign rec_pop = res_push;

	assign h = rec.hdr;
	assign v2 = (h[7][3:2] == 2'b10);
	assign trainer = h[6][2];
	assign battery = h[6][1];
	assign short_img = (rec.count < HDR_BYTES);
	assign sig_ok = (h[0] == SIG_0) && (h[1] == SIG_1) && (h[2] == SIG_2) && (h[3] == SIG_3);

	always_comb begin
		if (v2) begin
			mapper = {h[8][3:0], h[7][7:4], h[6][7:4]};
			sub = h[8][7:4];
			prg_units = {h[9][3:0], h[4]};
			chr_units = {h[9][7:4], h[5]};
			pram = ram_shift(h[10][3:0]);
			pnv = ram_shift(h[10][7:4]);
			cram = ram_shift(h[11][3:0]);
			cnv = ram_shift(h[11][7:4]);
			tv = h[12][1:0];
			console = h[13][1:0];
		end else begin
			mapper = {4'd0, h[7][7:4], h[6][7:4]};
			sub = 4'd0;
			prg_units = {4'd0, h[4]};
			chr_units = {4'd0, h[5]};
			pram = (h[8] == 8'd0) ? 22'h2000 : {1'b0, h[8], 13'd0};
			pnv = battery ? pram : 22'd0;
			cram = (h[5] == 8'd0) ? 22'h2000 : 22'd0;
			cnv = 22'd0;
			tv = {1'b0, h[9][0]};
			console = 2'd0;
		end
	end

	assign prg = {prg_units, 14'd0};
	assign chr = {chr_units, 13'd0};

	always_comb begin
		priority if (h[6][3]) begin
			mirror = MIRROR_FOUR;
		end else if (h[6][0]) begin
			mirror = MIRROR_VERT;
		end else begin
			mirror = MIRROR_HORIZ;
		end
	end

	assign need = HDR_BYTES + (trainer ? TRAINER_BYTES : 32'd0) + 32'(prg) + 32'(chr);

	always_comb begin
		priority if (console == CONSOLE_VS) begin
			status = ST_VS;
		end else if (console == CONSOLE_ARCADE) begin
			status = ST_ARCADE;
		end else if (prg == 26'd0) begin
			status = ST_ZERO_PRG;
		end else if (rec.count < need) begin
			status = ST_TRUNCATED;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		res = '0;
		priority if (short_img) begin
			res.status = ST_SHORT;
		end else if (!sig_ok) begin
			res.status = ST_BAD_SIG;
		end else begin
			res.status = status;
			res.header_flags = {console == CONSOLE_EXT, mirror, v2, battery, trainer};
			res.mapper_num = mapper;
			res.submapper = sub;
			res.prg_rom_bytes = prg;
			res.chr_rom_bytes = chr;
			res.prg_wram_bytes = pram;
			res.prg_nvram_bytes = pnv;
			res.chr_ram_bytes = cram;
			res.chr_nvram_bytes = cnv;
			res.timing_mode = tv;
			if (status == ST_OK) begin
				res.fingerprint = rec.hash ^ {20'd0, mapper, 32'd0} ^ {38'd0, prg}
					^ {23'd0, chr, 16'd0};
			end
		end
	end

endmodule

// ----- hw/rtl/rihp_checker.sv -----
// port-level checks for the cartridge header parser, bound to the top level
// depends on rihp_pkg and rom_image_header_parser
module rihp_checker import rihp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input in_item_t  item,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// errors never carry a fingerprint
	a_fp_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != ST_OK |-> result.fingerprint == 64'd0)
		else $error("fingerprint set on an error status");

	// short image or bad signature give no decoded fields
	a_early_reject_blank: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.status == ST_SHORT || result.status == ST_BAD_SIG)
		|-> result.header_flags == 6'd0 && result.mapper_num == 12'd0
			&& result.prg_rom_bytes == 26'd0 && result.prg_wram_bytes == 22'd0
			&& result.chr_ram_bytes == 22'd0)
		else $error("fields decoded on an early reject");

	// old layout has no submapper and no chr nvram
	a_old_layout: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.header_flags[2]
		|-> result.submapper == 4'd0 && result.chr_nvram_bytes == 22'd0)
		else $error("v2-only fields set for an old header");

	// a waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

endmodule

bind rom_image_header_parser rihp_checker u_rihp_checker (.*);
